FILE: sv/lsbe_pkg.sv
// Shared types and constants for the LED strip SPI bit encoder.
// No dependencies; compiled first.
package lsbe_pkg;

	localparam int DEF_MAX_LEDS = 256;

	localparam int CNT_W   = 9;   // led_count register width
	localparam int LATCH_W = 8;   // reset_bytes register width
	localparam int CFG_W   = 9;   // widest configuration register
	localparam int COL_W   = 24;  // green, red, blue

	localparam logic [LATCH_W-1:0] RESET_BYTES_DEFAULT = 8'd140;

	// operation codes
	localparam logic [2:0] OP_SET_ONE   = 3'd0;
	localparam logic [2:0] OP_SET_ALL   = 3'd1;
	localparam logic [2:0] OP_REFRESH   = 3'd2;
	localparam logic [2:0] OP_MUTED_REF = 3'd3;
	localparam logic [2:0] OP_PULL      = 3'd4;

	// configuration register indexes
	localparam logic REG_LED_COUNT   = 1'b0;
	localparam logic REG_RESET_BYTES = 1'b1;

	// SPI line codes
	localparam logic [7:0] CODE_ONE   = 8'hFC;
	localparam logic [7:0] CODE_ZERO  = 8'h80;
	localparam logic [7:0] CODE_LATCH = 8'h00;

	localparam logic [4:0] LAST_BIT = 5'd23;  // bits per LED minus one

	typedef struct packed {
		logic [2:0]       op;
		logic [7:0]       idx;
		logic [COL_W-1:0] colour;
	} cmd_t;

	typedef struct packed {
		logic clearing;  // store clearing pass after reset
	} back_stat_t;

endpackage

FILE: sv/lsbe_ifs.sv
// Request and byte channel interfaces of the LED strip SPI bit encoder.
// Depends on nothing; compiled after lsbe_pkg.
interface lsbe_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, operation, led_index, red, green, blue, input ready);
	modport sink   (input valid, operation, led_index, red, green, blue, output ready);
endinterface

interface lsbe_spi_if;
	logic       valid;
	logic       ready;
	logic [7:0] spi_byte;
	logic       frame_last;

	modport source (output valid, spi_byte, frame_last, input ready);
	modport sink   (input valid, spi_byte, frame_last, output ready);
endinterface

FILE: sv/lsbe_front.sv
// Front end: takes requests, drops unused codes, queues commands (two deep).
// Depends on lsbe_pkg and lsbe_ifs.
module lsbe_front
	import lsbe_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	lsbe_cmd_if.sink       cmd,
	input  back_stat_t     stat,
	output logic           q_valid,
	output cmd_t           q_cmd,
	input  logic           q_pop
);

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       known;
	logic       push;

	always_comb begin
		unique case (cmd.operation)
			OP_SET_ONE, OP_SET_ALL, OP_REFRESH, OP_MUTED_REF, OP_PULL: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign cmd.ready = (cnt_q != 2'd2) && !stat.clearing;
	// unknown codes are accepted and dropped
	assign push      = cmd.valid && cmd.ready && known;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_cmd     = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= '{op: cmd.operation, idx: cmd.led_index,
				colour: {cmd.green, cmd.red, cmd.blue}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (q_pop)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

FILE: sv/lsbe_back.sv
// Back end: colour store, set-all and clearing sweeper, frame sequencer,
// pull pipeline and two-entry output queue. Depends on lsbe_pkg and lsbe_ifs.
module lsbe_back
	import lsbe_pkg::*;
#(
	parameter int MAX_LEDS = DEF_MAX_LEDS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output back_stat_t         stat,
	input  logic [CNT_W-1:0]   led_count,
	input  logic [LATCH_W-1:0] reset_bytes,
	lsbe_spi_if.source         spi
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [COL_W-1:0]   mem [MAX_LEDS];

	logic [1:0]         state_q;
	logic [AW-1:0]      sw_addr_q;
	logic [AW-1:0]      sw_last_q;
	logic [COL_W-1:0]   sw_col_q;

	logic               pending_q;
	logic               active_q;
	logic               muted_q;
	logic               in_data_q;
	logic [CNT_W-1:0]   frame_leds_q;
	logic [LATCH_W-1:0] frame_latch_q;
	logic [CNT_W-1:0]   led_q;
	logic [4:0]         bit_q;
	logic [LATCH_W-1:0] lat_q;

	logic               valid_s1;
	logic               data_s1;
	logic               muted_s1;
	logic               last_s1;
	logic [4:0]         bitsel_s1;
	logic [COL_W-1:0]   rd_s1;

	logic [7:0]         obyte_q [2];
	logic               olast_q [2];
	logic               owptr_q;
	logic               orptr_q;
	logic [1:0]         ocnt_q;

	logic [CNT_W-1:0]   eff;
	logic               opop;
	logic               credit;
	logic               issue;
	logic               last_now;
	logic               we;
	logic [AW-1:0]      wa;
	logic [COL_W-1:0]   wd;
	logic               in_range;
	logic [7:0]         byte_s1;

	always_comb begin
		if (32'(led_count) > MAX_LEDS)
			eff = CNT_W'(MAX_LEDS);
		else
			eff = led_count;
	end

	assign stat.clearing = (state_q == ST_CLEAR);
	assign in_range      = ({1'b0, q_cmd.idx} < eff);

	// output queue drains one byte a cycle while the receiver is ready; keep room for what is in flight
	assign opop   = spi.valid && spi.ready;
	assign credit = ({1'b0, valid_s1} + ocnt_q - {1'b0, opop}) < 2'd2;

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_RUN && q_valid) begin
			if (q_cmd.op == OP_PULL && active_q)
				q_pop = credit;
			else
				q_pop = 1'b1;
		end
	end

	assign issue = q_pop && q_cmd.op == OP_PULL && active_q;

	always_comb begin
		if (in_data_q)
			last_now = (led_q == frame_leds_q - CNT_W'(1)) && (bit_q == LAST_BIT)
				&& (frame_latch_q == '0);
		else
			last_now = (lat_q == frame_latch_q - LATCH_W'(1));
	end

	// single write port: sweeper or set one
	always_comb begin
		we = 1'b0;
		wa = sw_addr_q;
		wd = sw_col_q;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wd = '0;
			end
			ST_SWEEP: we = 1'b1;
			default: begin
				we = q_pop && q_cmd.op == OP_SET_ONE && in_range;
				wa = AW'(q_cmd.idx);
				wd = q_cmd.colour;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (issue)
			rd_s1 <= mem[AW'(led_q)];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1   <= in_data_q;
			muted_s1  <= muted_q;
			last_s1   <= last_now;
			bitsel_s1 <= LAST_BIT - bit_q;
		end
		if (state_q == ST_RUN && q_pop && q_cmd.op == OP_SET_ALL)
			sw_col_q <= q_cmd.colour;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			sw_addr_q     <= '0;
			sw_last_q     <= AW'(MAX_LEDS - 1);
			pending_q     <= 1'b0;
			active_q      <= 1'b0;
			muted_q       <= 1'b0;
			in_data_q     <= 1'b0;
			frame_leds_q  <= '0;
			frame_latch_q <= '0;
			led_q         <= '0;
			bit_q         <= '0;
			lat_q         <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= issue;
			unique case (state_q)
				ST_CLEAR, ST_SWEEP: begin
					if (sw_addr_q == sw_last_q)
						state_q <= ST_RUN;
					else
						sw_addr_q <= sw_addr_q + AW'(1);
				end
				default: begin
					if (q_pop) begin
						case (q_cmd.op)
							OP_SET_ONE: begin
								if (in_range)
									pending_q <= 1'b1;
							end
							OP_SET_ALL: begin
								pending_q <= 1'b1;
								if (eff != '0) begin
									state_q   <= ST_SWEEP;
									sw_addr_q <= '0;
									sw_last_q <= AW'(eff - CNT_W'(1));
								end
							end
							OP_REFRESH, OP_MUTED_REF: begin
								if (!active_q && (q_cmd.op == OP_MUTED_REF || pending_q)) begin
									if (q_cmd.op == OP_REFRESH)
										pending_q <= 1'b0;
									if (eff != '0 || reset_bytes != '0) begin
										active_q      <= 1'b1;
										muted_q       <= (q_cmd.op == OP_MUTED_REF);
										in_data_q     <= (eff != '0);
										frame_leds_q  <= eff;
										frame_latch_q <= reset_bytes;
										led_q         <= '0;
										bit_q         <= '0;
										lat_q         <= '0;
									end
								end
							end
							OP_PULL: begin
								if (active_q) begin
									if (last_now)
										active_q <= 1'b0;
									if (in_data_q) begin
										if (bit_q == LAST_BIT) begin
											bit_q <= '0;
											led_q <= led_q + CNT_W'(1);
											if (led_q == frame_leds_q - CNT_W'(1))
												in_data_q <= 1'b0;
										end else begin
											bit_q <= bit_q + 5'd1;
										end
									end else begin
										lat_q <= lat_q + LATCH_W'(1);
									end
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	always_comb begin
		if (!data_s1)
			byte_s1 = CODE_LATCH;
		else if (muted_s1 || !rd_s1[bitsel_s1])
			byte_s1 = CODE_ZERO;
		else
			byte_s1 = CODE_ONE;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			obyte_q[owptr_q] <= byte_s1;
			olast_q[owptr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (valid_s1)
				owptr_q <= ~owptr_q;
			if (opop)
				orptr_q <= ~orptr_q;
			ocnt_q <= ocnt_q + {1'b0, valid_s1} - {1'b0, opop};
		end
	end

	assign spi.valid      = (ocnt_q != 2'd0);
	assign spi.spi_byte   = obyte_q[orptr_q];
	assign spi.frame_last = olast_q[orptr_q];

endmodule

FILE: sv/led_strip_spi_bit_encoder_unit.sv
// LED strip SPI bit encoder, top level: configuration registers, front end
// and back end. Depends on lsbe_pkg, lsbe_ifs, lsbe_front and lsbe_back.
//
// Usage:
//  - cmd channel (valid/ready): requests to set one LED, set all LEDs,
//    request a normal or muted frame, or pull the next SPI byte.
//  - spi channel (valid/ready): one byte per pull while a frame runs;
//    frame_last marks the final latch or data byte.
//  - cfg port: write led_count (index 0) and reset_bytes (index 1) while idle.
// Throughput: one request per cycle for set one, refreshes and pulls, as long
//  as the output queue has room for pulls; the limit is the single write and
//  read port of the colour store. Set all walks the store at one LED per cycle,
//  so it holds the queue until min(led_count, MAX_LEDS) LEDs are written.
// Pull path: a pulled byte is registered at the store read, then in the output
//  queue, before it is offered.
// Reset: the colour store is cleared by a pass over all MAX_LEDS entries; cmd.ready
//  stays low until it is done. Config writes are taken throughout.
// Receiver stall: bytes wait in a two-entry output queue; pulls then hold in
//  the two-entry request queue and cmd.ready drops when that fills.
module led_strip_spi_bit_encoder_unit
	import lsbe_pkg::*;
#(
	parameter int MAX_LEDS = DEF_MAX_LEDS
) (
	input  logic             clk,
	input  logic             arst_n,
	lsbe_cmd_if.sink         cmd,
	lsbe_spi_if.source       spi,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	logic [CNT_W-1:0]   led_count_q;
	logic [LATCH_W-1:0] reset_bytes_q;

	logic       q_valid;
	cmd_t       q_cmd;
	logic       q_pop;
	back_stat_t stat;

	// config registers; frames latch them at start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q   <= '0;
			reset_bytes_q <= RESET_BYTES_DEFAULT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LED_COUNT:   led_count_q   <= cfg_wr_data[CNT_W-1:0];
				REG_RESET_BYTES: reset_bytes_q <= cfg_wr_data[LATCH_W-1:0];
				default: ;
			endcase
		end
	end

	lsbe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	lsbe_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.stat        (stat),
		.led_count   (led_count_q),
		.reset_bytes (reset_bytes_q),
		.spi         (spi)
	);

endmodule

FILE: dv/tb_top.sv
// Testbench for the LED strip SPI bit encoder: drives requests, predicts every
// SPI byte and checks it against the byte channel. Needs lsbe_pkg, lsbe_ifs and
// the led_strip_spi_bit_encoder_unit RTL; reads no files.
module tb_top;
	import lsbe_pkg::*;

	// One byte on the SPI channel as the predictor sees it.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} spi_word_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wr_data;

	lsbe_cmd_if cmd ();
	lsbe_spi_if spi ();

	led_strip_spi_bit_encoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.spi        (spi),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	// ---------------------------------------------------------------
	// Predictor state: colour store, dirty flag, frame in progress and
	// the two registers. Frame length is latched when a frame opens.
	// ---------------------------------------------------------------
	logic [COL_W-1:0]   grb_store [DEF_MAX_LEDS];
	logic               dirty;
	logic               on_air;
	logic               quiet;       // muted frame: every data bit goes out as zero
	int unsigned        pos;
	int unsigned        frm_leds;
	int unsigned        frm_latch;
	logic [CNT_W-1:0]   cnt_reg;
	logic [LATCH_W-1:0] latch_reg;

	spi_word_t spi_due [$];   // bytes still owed by the block, oldest first

	int bad_count;
	int item_count;            // requests that changed state or produced a byte
	int idle_pct;              // sender gap probability per cycle
	int stall_pct;             // receiver stall probability per cycle

	// led_count above the store size acts as the store size
	function automatic int unsigned strip_len();
		return (cnt_reg > DEF_MAX_LEDS) ? DEF_MAX_LEDS : cnt_reg;
	endfunction

	function automatic void open_frame(input logic muted);
		int unsigned n;
		n = strip_len();
		// nothing to send at all: the frame never starts
		if (n * COL_W + latch_reg == 0)
			return;
		frm_leds  = n;
		frm_latch = latch_reg;
		quiet     = muted;
		pos       = 0;
		on_air    = 1'b1;
	endfunction

	// Applies one accepted request; queues the byte a pull produces.
	// Returns 1 when the request had any effect.
	function automatic bit encode_request(input logic [2:0] op, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [COL_W-1:0] grb;
		int unsigned      n;
		int unsigned      data_len;
		spi_word_t        w;
		grb = {g, r, b};
		n   = strip_len();
		case (op)
			OP_SET_ONE: begin
				if (idx >= n)
					return 0;
				grb_store[idx] = grb;
				dirty = 1'b1;
				return 1;
			end
			OP_SET_ALL: begin
				for (int i = 0; i < n; i++)
					grb_store[i] = grb;
				dirty = 1'b1;
				return 1;
			end
			OP_REFRESH: begin
				// only with unsent changes; the flag clears even for an empty frame
				if (on_air || !dirty)
					return 0;
				dirty = 1'b0;
				open_frame(1'b0);
				return 1;
			end
			OP_MUTED_REF: begin
				if (on_air)
					return 0;
				open_frame(1'b1);
				return 1;
			end
			OP_PULL: begin
				if (!on_air)
					return 0;
				data_len = frm_leds * COL_W;
				if (pos >= data_len)
					w.code = CODE_LATCH;
				else if (quiet)
					w.code = CODE_ZERO;
				else
					// store is read live, so late writes to unsent LEDs show up
					w.code = grb_store[pos / COL_W][LAST_BIT - pos % COL_W] ?
						CODE_ONE : CODE_ZERO;
				w.last = (pos + 1 >= data_len + frm_latch);
				if (w.last) begin
					on_air = 1'b0;
					pos    = 0;
				end else begin
					pos++;
				end
				spi_due.push_back(w);
				return 1;
			end
			default: return 0;   // spare op codes do nothing
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Clock, receiver side and result check
	// ---------------------------------------------------------------
	always #5 clk = ~clk;

	// byte channel back-pressure
	always @(posedge clk) begin
		spi.ready <= ($urandom_range(99) >= stall_pct);
	end

	// every byte taken must match the oldest owed byte
	always @(posedge clk) begin
		spi_word_t want;
		if (arst_n && spi.valid === 1'b1 && spi.ready) begin
			if (spi_due.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: byte %h last %b with none owed", $realtime,
						spi.spi_byte, spi.frame_last);
			end else begin
				want = spi_due.pop_front();
				if (spi.spi_byte !== want.code || spi.frame_last !== want.last) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: byte exp %h got %h, last exp %b got %b",
							$realtime, want.code, spi.spi_byte, want.last,
							spi.frame_last);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Request side helpers
	// ---------------------------------------------------------------

	// Offers one request and waits for the handshake; valid stays high after
	// acceptance so back-to-back requests need no extra edge.
	task automatic send_req(input logic [2:0] op, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.operation <= op;
		cmd.led_index <= idx;
		cmd.red       <= r;
		cmd.green     <= g;
		cmd.blue      <= b;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (encode_request(op, idx, r, g, b))
			item_count++;
	endtask

	task automatic pull();
		send_req(OP_PULL, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic set_one(input logic [7:0] idx);
		send_req(OP_SET_ONE, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	task automatic set_all();
		send_req(OP_SET_ALL, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic frame_req(input logic [2:0] op);
		send_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// pull until the running frame is done
	task automatic drain();
		while (on_air)
			pull();
	endtask

	// Block goes quiet: no request in flight, all bytes delivered, and enough
	// time for a full set-all walk plus the output pipeline.
	task automatic settle();
		cmd.valid <= 1'b0;
		while (spi_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		if (idx == REG_LED_COUNT)
			cnt_reg = data;
		else
			latch_reg = data[LATCH_W-1:0];
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// top data bit is don't-care for reset_bytes; toggle it anyway
	task automatic configure(input logic [CNT_W-1:0] n, input logic [LATCH_W-1:0] lat);
		settle();
		write_reg(REG_LED_COUNT, n);
		write_reg(REG_RESET_BYTES, {1'($urandom_range(1)), lat});
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset values: no LEDs, 140 latch bytes, nothing pending.
	task automatic test_after_reset();
		pull();                           // no frame, no byte
		for (int k = OP_PULL + 1; k < 8; k++)
			send_req(3'(k), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		set_one(8'd0);                    // out of range with zero LEDs
		frame_req(OP_REFRESH);            // nothing pending
		frame_req(OP_MUTED_REF);          // latch-only frame
		drain();
	endtask

	// Zero LEDs and zero latch bytes: frames never start.
	task automatic test_empty_frame();
		configure(9'd0, 8'd0);
		set_all();                        // marks pending, writes nothing
		frame_req(OP_REFRESH);            // clears pending, no frame
		frame_req(OP_MUTED_REF);
		pull();
		frame_req(OP_REFRESH);
	endtask

	// One LED: colour extremes, out-of-range index, muted vs. pending.
	task automatic test_single_led();
		configure(9'd1, 8'd1);
		send_req(OP_SET_ONE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_req(OP_SET_ONE, 8'd255, 8'h00, 8'h00, 8'h00);   // ignored
		frame_req(OP_REFRESH);
		drain();
		frame_req(OP_REFRESH);                                // nothing pending now
		pull();
		send_req(OP_SET_ONE, 8'd0, 8'h00, 8'h00, 8'h00);
		frame_req(OP_MUTED_REF);                              // pending survives
		drain();
		frame_req(OP_REFRESH);
		drain();
		send_req(OP_SET_ALL, 8'd0, 8'h01, 8'h80, 8'h5A);
		frame_req(OP_REFRESH);
		drain();
	endtask

	// Writes during a frame: unsent LEDs change live; refreshes are dropped.
	task automatic test_live_update();
		configure(9'd3, 8'd2);
		set_all();
		frame_req(OP_REFRESH);
		repeat (10) pull();
		frame_req(OP_REFRESH);
		frame_req(OP_MUTED_REF);
		set_one(8'd2);                    // not yet sent
		set_one(8'd0);                    // partly sent: its unsent bits change live
		drain();
		frame_req(OP_REFRESH);
		repeat (30) pull();
		set_all();                        // overwrites what is left of the frame
		drain();
	endtask

	// Register writes inside a frame apply only from the next frame.
	task automatic test_config_mid_frame();
		configure(9'd2, 8'd3);
		set_one(8'd1);
		frame_req(OP_REFRESH);
		repeat (5) pull();
		configure(9'd5, 8'd7);
		drain();
		set_all();
		frame_req(OP_REFRESH);
		drain();
	endtask

	// Largest strip, sent back to back with no idling. A count beyond the
	// store acts as the full store. The frame is left running at the end.
	task automatic test_full_strip();
		idle_pct  = 0;
		stall_pct = 0;
		configure(9'h1FF, 8'd255);
		set_all();
		set_one(8'd255);
		set_one(8'd0);
		frame_req(OP_REFRESH);
		repeat (240) pull();
		frame_req(OP_REFRESH);            // dropped while the frame runs
		idle_pct  = 30;
		stall_pct = 30;
	endtask

	// Mostly well-formed rounds (sets, one refresh, pulls to the end of
	// the frame) with random requests mixed in.
	task automatic test_random_traffic();
		int           first;
		int unsigned  n;
		int unsigned  lat;
		logic [2:0]   op;
		first = item_count;
		while (item_count - first < 900) begin
			case ($urandom_range(9))
				0:       n = 0;
				7, 8:    n = $urandom_range(16, 5);
				default: n = $urandom_range(4, 1);
			endcase
			lat = ($urandom_range(7) == 0) ? $urandom_range(255, 100) : $urandom_range(12);
			configure(CNT_W'(n), LATCH_W'(lat));
			repeat ($urandom_range(5, 2)) begin
				repeat ($urandom_range(4)) begin
					case ($urandom_range(9))
						0:       set_all();
						1:       set_one(8'($urandom_range(255)));
						default: set_one((strip_len() == 0) ? 8'd0 :
							8'($urandom_range(strip_len() - 1)));
					endcase
				end
				frame_req(($urandom_range(3) == 0) ? OP_MUTED_REF : OP_REFRESH);
				while (on_air) begin
					if ($urandom_range(99) < 15) begin
						op = 3'($urandom_range(7));
						send_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
							8'($urandom_range(255)), 8'($urandom_range(255)));
					end else begin
						pull();
					end
				end
				if ($urandom_range(4) == 0)
					pull();               // stray pull after the frame
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_LED_COUNT;
		cfg_wr_data   = '0;
		cmd.valid     = 1'b0;
		cmd.operation = OP_PULL;
		cmd.led_index = '0;
		cmd.red       = '0;
		cmd.green     = '0;
		cmd.blue      = '0;
		spi.ready     = 1'b0;
		for (int i = 0; i < DEF_MAX_LEDS; i++)
			grb_store[i] = '0;
		dirty      = 1'b0;
		on_air     = 1'b0;
		quiet      = 1'b0;
		pos        = 0;
		frm_leds   = 0;
		frm_latch  = 0;
		cnt_reg    = '0;
		latch_reg  = RESET_BYTES_DEFAULT;
		bad_count  = 0;
		item_count = 0;
		idle_pct   = 30;
		stall_pct  = 30;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// store clearing after reset shows as cmd.ready low; send_req waits it out

		test_after_reset();
		test_empty_frame();
		test_single_led();
		test_live_update();
		test_config_mid_frame();
		test_random_traffic();
		test_full_strip();

		cmd.valid <= 1'b0;
		for (int w = 0; w < 20000 && spi_due.size() != 0; w++)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (bad_count == 0 && spi_due.size() == 0)
			$display("led_strip_spi_bit_encoder_unit: match");
		else
			$display("led_strip_spi_bit_encoder_unit: mismatch");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#5000000;
		$display("led_strip_spi_bit_encoder_unit: mismatch");
		$finish;
	end

endmodule
